// ----- sv/assert_macros.svh -----
// assertion helpers used by the queue top-level rtl file
// each macro is sampled on the rising edge of clk and is off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication to the next edge
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/mhpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and constants of the multikey priority queue
// Entry layout, key order, request and status codes, cell control group.
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// number of entries the queue holds
	localparam int CAPACITY = 64;
	// width of the fill count, wide enough to hold CAPACITY itself
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// width of the reported entry count
	localparam int OUT_CNT_W = 7;

	// request kinds
	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_SERVE  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// packed entry, urgency most significant
	typedef struct packed {
		logic [7:0]  urgency;
		logic [7:0]  age;
		logic [15:0] arr_order;
	} entry_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic srv;
	} cell_ctl_t;

	// true when a is served before b: higher urgency, then higher age,
	// then smaller arrival order
	function automatic logic ahead_of(entry_t a, entry_t b);
		logic [31:0] ka;
		logic [31:0] kb;
		ka = {a.urgency, a.age, ~a.arr_order};
		kb = {b.urgency, b.age, ~b.arr_order};
		return ka > kb;
	endfunction

endpackage
`default_nettype wire

// ----- sv/mhpq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mhpq_cell: one slot of the sorted queue
// Holds one entry; on insert it keeps, takes the new entry or takes its left
// neighbor's entry; on serve it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module mhpq_cell (
	input  wire                   clk,
	input  mhpq_pkg::cell_ctl_t   ctl,
	input  wire                   valid,       // slot lies below the fill count
	input  mhpq_pkg::entry_t      new_entry,   // entry being inserted
	input  mhpq_pkg::entry_t      prev_entry,  // left neighbor, nearer the head
	input  wire                   prev_stays,  // left neighbor keeps its entry
	input  mhpq_pkg::entry_t      next_entry,  // right neighbor, nearer the tail
	output mhpq_pkg::entry_t      entry,
	output logic                  stays
);

	mhpq_pkg::entry_t entry_q;

	// own entry is at least as far ahead as the new one
	assign stays = valid && !mhpq_pkg::ahead_of(new_entry, entry_q);
	assign entry = entry_q;

	// insert opens a gap at the first cell that does not stay, serve shifts
	// toward the head
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!stays) begin
				entry_q <= prev_stays ? new_entry : prev_entry;
			end
		end else if (ctl.srv) begin
			entry_q <= next_entry;
		end
	end

endmodule
`default_nettype wire

// ----- sv/multikey_heap_priority_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// multikey_heap_priority_queue: priority queue over urgency, age, arrival
// Insert and serve requests on one stream, one result item per request.
// ----------------------------------------------------------------------------
// The queue holds up to CAPACITY entries in a row of cells kept in service
// order, head in cell 0: highest urgency first, then greater age, then the
// smaller arrival order. An insert broadcasts the new entry to all cells,
// each compares it with its own and the row opens a gap; a serve shifts the
// row one place toward the head. The result of each item appears on the
// output register in the cycle after acceptance; the input is ready whenever
// that register is empty or being taken, so one item per cycle is sustained
// while the result side keeps taking. The clock period is set by the 32-bit
// key compare in each cell plus the keep/insert/shift select. Serving an
// empty queue returns status empty, inserting into a full queue returns
// status full; both leave the contents unchanged. No clearing pass is needed
// after reset.
module multikey_heap_priority_queue (
	input  wire         clk,
	input  wire         arst_n,
	// request stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // entry_age[7:0], entry_urgency[15:8], arrival_order[31:16]
	input  wire  [0:0]  s_tuser,   // req_type[0]
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // served_age[7:0], served_urgency[15:8],
	                               // served_order[31:16], entry_count[38:32], zero[39]
	output logic [1:0]  m_tuser    // status[1:0]
);

	localparam int CAP = mhpq_pkg::CAPACITY;
	localparam int CW  = mhpq_pkg::CNT_W;

	logic                  accept;
	logic                  is_ins;
	logic                  full;
	logic                  empty;
	mhpq_pkg::cell_ctl_t   ctl;
	mhpq_pkg::entry_t      new_entry;
	mhpq_pkg::entry_t      cell_entry [CAP];
	logic                  cell_stays [CAP];
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_next;

	logic                  out_valid_q;
	mhpq_pkg::entry_t      served_q;
	mhpq_pkg::status_t     status_q;
	logic [CW-1:0]         out_count_q;
	logic                  head_ok;

	// request decode
	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign is_ins    = (s_tuser[0] == mhpq_pkg::REQ_INSERT);
	assign full      = (count_q == CW'(CAP));
	assign empty     = (count_q == '0);
	assign ctl.ins   = accept && is_ins && !full;
	assign ctl.srv   = accept && !is_ins && !empty;
	assign new_entry = '{urgency: s_tdata[15:8], age: s_tdata[7:0], arr_order: s_tdata[31:16]};

	// row of cells, head at index 0
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		mhpq_pkg::entry_t prev_e;
		mhpq_pkg::entry_t next_e;
		logic             prev_s;
		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_s = 1'b1;
		end else begin : g_body
			assign prev_e = cell_entry[i-1];
			assign prev_s = cell_stays[i-1];
		end
		if (i == CAP - 1) begin : g_tail
			assign next_e = cell_entry[i];
		end else begin : g_mid
			assign next_e = cell_entry[i+1];
		end
		mhpq_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.valid      (CW'(i) < count_q),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.prev_stays (prev_s),
			.next_entry (next_e),
			.entry      (cell_entry[i]),
			.stays      (cell_stays[i])
		);
	end

	// fill count
	always_comb begin
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CW'(1);
		end else if (ctl.srv) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			served_q    <= ctl.srv ? cell_entry[0] : '0;
			out_count_q <= count_next;
			if (is_ins) begin
				status_q <= full ? mhpq_pkg::ST_FULL : mhpq_pkg::ST_INSERTED;
			end else begin
				status_q <= empty ? mhpq_pkg::ST_EMPTY : mhpq_pkg::ST_SERVED;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, mhpq_pkg::OUT_CNT_W'(out_count_q), served_q.arr_order,
	                   served_q.urgency, served_q.age};
	assign m_tuser  = status_q;

	// head never trails the second cell
	assign head_ok = (count_q < CW'(2)) || !mhpq_pkg::ahead_of(cell_entry[1], cell_entry[0]);

	`ASSERT_ALWAYS(a_count_range, count_q <= CW'(CAP), "fill count above capacity")
	`ASSERT_ALWAYS(a_head_order, head_ok, "head entry is behind the second entry")
	`ASSERT_NEXT(a_refused_keeps, accept && is_ins && full, count_q == $past(count_q), "refused insert changed the fill count")
	`ASSERT_NEXT(a_result_follows, accept, m_tvalid, "accepted item gave no result")

endmodule
`default_nettype wire

// ----- bench/heap_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap_result_checker: predicts and checks every result of the priority queue
// Watches both streams, keeps its own binary heap of entries, and compares
// each result item field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module heap_result_checker
	import mhpq_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	input  wire         s_tready,
	input  wire  [31:0] s_tdata,   // entry_age[7:0], entry_urgency[15:8], arrival_order[31:16]
	input  wire  [0:0]  s_tuser,   // req_type[0]
	input  wire         m_tvalid,
	input  wire         m_tready,
	input  wire  [39:0] m_tdata,   // served_age[7:0], served_urgency[15:8],
	                               // served_order[31:16], entry_count[38:32], zero[39]
	input  wire  [1:0]  m_tuser,   // status[1:0]
	output int          failures,
	output int          backlog,
	output int          checked,
	output int          full_hits,
	output int          empty_hits
);

	// one predicted reply of the queue
	typedef struct packed {
		entry_t     served;
		status_t    status;
		logic [6:0] count;
	} reply_t;

	reply_t reply_backlog[$];
	entry_t heap_mem[CAPACITY];
	int     heap_fill = 0;
	int     fail_count = 0;
	int     reply_count = 0;
	int     backlog_depth = 0;
	int     full_count = 0;
	int     empty_count = 0;

	assign failures   = fail_count;
	assign backlog    = backlog_depth;
	assign checked    = reply_count;
	assign full_hits  = full_count;
	assign empty_hits = empty_count;

	// service order: urgency, then age, then the earlier arrival
	function automatic bit serves_before(entry_t a, entry_t b);
		if (a.urgency != b.urgency)
			return a.urgency > b.urgency;
		if (a.age != b.age)
			return a.age > b.age;
		return a.arr_order < b.arr_order;
	endfunction

	task automatic report_mismatch(input string field, input logic [39:0] got,
		input logic [39:0] want);
		$display("mismatch on %s in result %0d: got %0h, expected %0h",
			field, reply_count, got, want);
		fail_count++;
	endtask

	// apply one request to the heap copy and queue the reply it causes
	task automatic predict_request(input logic req, input logic [31:0] data);
		reply_t reply;
		entry_t item;
		entry_t tmp;
		int     pos;
		int     parent;
		int     best;
		int     kid;
		reply = '0;
		item.age = data[7:0];
		item.urgency = data[15:8];
		item.arr_order = data[31:16];
		if (req == REQ_INSERT) begin
			if (heap_fill >= CAPACITY) begin
				reply.status = ST_FULL;
				full_count++;
			end else begin
				// place at the end and sift up
				heap_mem[heap_fill] = item;
				pos = heap_fill;
				heap_fill++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!serves_before(heap_mem[pos], heap_mem[parent]))
						break;
					tmp = heap_mem[pos];
					heap_mem[pos] = heap_mem[parent];
					heap_mem[parent] = tmp;
					pos = parent;
				end
				reply.status = ST_INSERTED;
			end
		end else if (heap_fill == 0) begin
			reply.status = ST_EMPTY;
			empty_count++;
		end else begin
			// take the head, move the last entry up and sift down
			reply.served = heap_mem[0];
			heap_fill--;
			heap_mem[0] = heap_mem[heap_fill];
			pos = 0;
			forever begin
				best = pos;
				kid = 2 * pos + 1;
				if (kid < heap_fill && serves_before(heap_mem[kid], heap_mem[best]))
					best = kid;
				if (kid + 1 < heap_fill && serves_before(heap_mem[kid + 1], heap_mem[best]))
					best = kid + 1;
				if (best == pos)
					break;
				tmp = heap_mem[pos];
				heap_mem[pos] = heap_mem[best];
				heap_mem[best] = tmp;
				pos = best;
			end
			reply.status = ST_SERVED;
		end
		reply.count = 7'(heap_fill);
		reply_backlog.push_back(reply);
	endtask

	// compare one result item with the oldest prediction
	task automatic check_reply();
		reply_t want;
		if (reply_backlog.size() == 0) begin
			report_mismatch("unrequested result", m_tdata, '0);
			return;
		end
		want = reply_backlog.pop_front();
		reply_count++;
		if (m_tdata[7:0] !== want.served.age)
			report_mismatch("served_age", 40'(m_tdata[7:0]), 40'(want.served.age));
		if (m_tdata[15:8] !== want.served.urgency)
			report_mismatch("served_urgency", 40'(m_tdata[15:8]),
				40'(want.served.urgency));
		if (m_tdata[31:16] !== want.served.arr_order)
			report_mismatch("served_order", 40'(m_tdata[31:16]),
				40'(want.served.arr_order));
		if (m_tdata[38:32] !== want.count)
			report_mismatch("entry_count", 40'(m_tdata[38:32]), 40'(want.count));
		if (m_tdata[39] !== 1'b0)
			report_mismatch("padding bit", 40'(m_tdata[39]), '0);
		if (m_tuser !== want.status)
			report_mismatch("status", 40'(m_tuser), 40'(want.status));
	endtask

	// results first: a result never belongs to a request taken at the same edge
	always @(posedge clk) begin
		if (!arst_n) begin
			reply_backlog.delete();
			heap_fill = 0;
		end else begin
			if (m_tvalid && m_tready)
				check_reply();
			if (s_tvalid && s_tready)
				predict_request(s_tuser[0], s_tdata);
		end
		backlog_depth = reply_backlog.size();
	end

endmodule

// ----- bench/multikey_heap_priority_queue_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multikey_heap_priority_queue_test: stimulus and verdict for the queue
// Directed corner requests, then fill, drain and mixed phases of random
// requests with random gaps on both streams; a checker predicts each result.
// ----------------------------------------------------------------------------
module multikey_heap_priority_queue_test;
	import mhpq_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_GAP      = 14;

	typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [31:0] s_tdata = '0;   // entry_age[7:0], entry_urgency[15:8], arrival_order[31:16]
	logic [0:0]  s_tuser = '0;   // req_type[0]
	logic        m_tready = 1'b0;
	wire         s_tready;
	wire         m_tvalid;
	wire  [39:0] m_tdata;        // served_age[7:0], served_urgency[15:8],
	                             // served_order[31:16], entry_count[38:32], zero[39]
	wire  [1:0]  m_tuser;        // status[1:0]

	int failures;
	int backlog;
	int checked;
	int full_hits;
	int empty_hits;
	int inserts_sent = 0;
	int serves_sent = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	multikey_heap_priority_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	heap_result_checker reply_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.failures   (failures),
		.backlog    (backlog),
		.checked    (checked),
		.full_hits  (full_hits),
		.empty_hits (empty_hits)
	);

	// 100 MHz clock
	initial begin
		forever #5 clk = ~clk;
	end

	// stall counter: ends the run when no item moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no item moved for %0d cycles", idle_cycles);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// result side: random stall before taking each item
	initial begin : result_sink
		int gap;
		wait (arst_n);
		@(negedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// offer one request after a random gap; called and returns at a falling edge
	task automatic send_request(input logic req, input logic [7:0] urg,
		input logic [7:0] age, input logic [15:0] ord);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {ord, urg, age};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (req == REQ_INSERT)
			inserts_sent++;
		else
			serves_sent++;
	endtask

	// serve with junk in the ignored key fields
	task automatic send_serve();
		send_request(REQ_SERVE, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// narrow keys make ties on urgency, age and arrival order frequent
	task automatic send_random(input int insert_pct, input bit narrow);
		logic req;
		req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_SERVE;
		if (narrow)
			send_request(req, 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				16'($urandom_range(0, 7)));
		else
			send_request(req, 8'($urandom), 8'($urandom), 16'($urandom));
	endtask

	// hold the request side until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (backlog != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		phase_kind_t kind;
		int          phase;
		int          random_sent;
		int          len;
		int          pct;
		bit          narrow;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: serve on empty, key extremes, tie-breaks, identical keys
		send_serve();
		send_request(REQ_INSERT, 8'd0, 8'd0, 16'd0);
		send_request(REQ_INSERT, 8'hff, 8'hff, 16'hffff);
		send_request(REQ_INSERT, 8'hff, 8'hff, 16'd0);
		send_request(REQ_INSERT, 8'hff, 8'd0, 16'd1);
		send_request(REQ_INSERT, 8'd128, 8'd7, 16'd100);
		send_request(REQ_INSERT, 8'd128, 8'd7, 16'd100);
		send_request(REQ_INSERT, 8'd128, 8'd8, 16'd200);
		send_request(REQ_INSERT, 8'd128, 8'd7, 16'd99);
		repeat (9) send_serve();
		wait_drained();

		// random phases cycle through filling, draining and mixed traffic
		phase = 0;
		random_sent = 0;
		while (random_sent < RANDOM_ITEMS) begin
			kind = phase_kind_t'(phase % 3);
			case (kind)
				PHASE_FILL:  pct = 85;
				PHASE_DRAIN: pct = 15;
				default:     pct = 50;
			endcase
			narrow = 1'($urandom_range(0, 1));
			no_idle = ($urandom_range(0, 3) == 0);
			len = $urandom_range(60, 150);
			repeat (len) send_random(pct, narrow);
			random_sent += len;
			if (phase == 0 || $urandom_range(0, 1))
				wait_drained();
			phase++;
		end

		// let the last results out, then give the verdict
		s_tvalid <= 1'b0;
		no_idle = 1'b0;
		while (backlog != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d inserts and %0d serves, %0d results compared",
			inserts_sent, serves_sent, checked);
		$display("queue refused as full %0d times, served empty %0d times",
			full_hits, empty_hits);
		if (backlog != 0)
			$display("%0d results never arrived", backlog);
		if (failures == 0 && backlog == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mhpq_pkg.sv
sv/mhpq_cell.sv
sv/multikey_heap_priority_queue.sv
bench/heap_result_checker.sv
bench/multikey_heap_priority_queue_test.sv
